// ----- rtl/ble_pkg.sv -----
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and constants of the battery level estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package ble_pkg;

  // Default sizes
  localparam int SAMPLE_COUNT_DEF = 8;
  localparam int ADC_BITS_DEF     = 10;

  // Field widths
  localparam int REF_W      = 12;
  localparam int PCT_W      = 7;
  localparam int VOLT_W     = 15;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int OFF_W      = 9;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REF_MV  = 1'b0,
    CFG_LOW_PCT = 1'b1
  } cfg_idx_e;

  localparam logic [REF_W-1:0] REF_MV_RESET  = 12'd1200;
  localparam logic [PCT_W-1:0] LOW_PCT_RESET = 7'd10;

  // Millivolt scaling: mean * ref * 11 >> 11, saturated
  localparam int                SCALE_SH = 11;
  localparam logic [VOLT_W-1:0] VOLT_MAX = 15'd32767;

  // Discharge curve breakpoints
  localparam logic [VOLT_W-1:0] CURVE_FULL_MV = 15'd4200;
  localparam logic [VOLT_W-1:0] CURVE_HIGH_MV = 15'd4000;
  localparam logic [VOLT_W-1:0] CURVE_MID_MV  = 15'd3600;
  localparam logic [VOLT_W-1:0] CURVE_LOW_MV  = 15'd3200;

  localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
  localparam logic [PCT_W-1:0] PCT_HIGH_BASE = 7'd90;
  localparam logic [PCT_W-1:0] PCT_MID_BASE  = 7'd10;

  // Offsets stay below 512, so x*205 >> k gives exact x/20, x/5 and x/40
  localparam logic [7:0] CURVE_RECIP = 8'd205;
  localparam int         PCT_HIGH_SH = 12;
  localparam int         PCT_MID_SH  = 10;
  localparam int         PCT_LOW_SH  = 13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TRIM,
    ST_DIV,
    ST_SCALE,
    ST_CURVE,
    ST_PCT
  } ble_state_e;

  typedef enum logic [2:0] {
    SEG_FULL,
    SEG_HIGH,
    SEG_MID,
    SEG_LOW,
    SEG_EMPTY
  } ble_seg_e;

endpackage

`default_nettype wire

// ----- rtl/ble_if.sv -----
// ----------------------------------------------------------------------------
// ble_if
// Valid/ready channels of the battery level estimator: sample in, report out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ble_sample_if #(
  parameter int ADC_BITS = ble_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ble_report_if;
  logic                        valid;
  logic                        ready;
  logic                        report_valid;
  logic [ble_pkg::PCT_W-1:0]   battery_percent;
  logic                        low_battery;
  logic [ble_pkg::VOLT_W-1:0]  voltage_mv;
  logic                        slow_mode_active;

  modport source (
    output valid, output report_valid, output battery_percent,
    output low_battery, output voltage_mv, output slow_mode_active,
    input ready
  );
  modport sink (
    input valid, input report_valid, input battery_percent,
    input low_battery, input voltage_mv, input slow_mode_active,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/ble_ring.sv -----
// ----------------------------------------------------------------------------
// ble_ring
// Sample ring: one write and one registered read port. Entries not yet
// written since reset read as zero, tracked by write pointer and wrap flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_ring #(
  parameter int DEPTH  = ble_pkg::SAMPLE_COUNT_DEF,
  parameter int DATA_W = ble_pkg::ADC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  input  wire logic [DATA_W-1:0]        push_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [DATA_W-1:0]        rd_data_o
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_valid_q;
  logic [IDX_W-1:0]  wr_ptr_q;
  logic              wrapped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      wrapped_q  <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= wrapped_q || (rd_addr_i < wr_ptr_q);
      if (push_i) begin
        if (wr_ptr_q == IDX_W'(DEPTH - 1)) begin
          wr_ptr_q  <= '0;
          wrapped_q <= 1'b1;
        end else begin
          wr_ptr_q <= wr_ptr_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/ble_mul.sv -----
// ----------------------------------------------------------------------------
// ble_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_mul #(
  parameter int A_W = 13,
  parameter int B_W = 17
) (
  input  wire logic               clk_i,
  input  wire logic [A_W-1:0]     a_i,
  input  wire logic [B_W-1:0]     b_i,
  output logic      [A_W+B_W-1:0] p_o
);

  logic [A_W+B_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (A_W + B_W)'(a_i) * (A_W + B_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- rtl/battery_level_estimator.sv -----
// ----------------------------------------------------------------------------
// battery_level_estimator
// Trimmed-mean battery gauge: ring of recent ADC samples, mean without the
// extremes, millivolt scaling, piecewise-linear charge curve, low flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one ADC sample per transfer; in_ch.ready is high only while
//   the sequencer is idle. out_ch carries exactly one result per sample.
//   Each sample takes a ring scan through its single read port followed by
//   three passes through the shared multiplier (mean, scaling, curve); a new
//   sample is taken only once the sequencer is back in idle.
//   The result sits in an output register: while out_ch is stalled the next
//   sample is still taken and worked on, and the sequencer holds in its last
//   step until the output register is free.
//   Configuration (cfg_we_i/cfg_idx_i/cfg_data_i) must be written while idle,
//   not enforced by the block; index 0 is the ADC reference in mV, 1 the low-level %.
//   Reset: ring reads as zero, reference 1200 mV, threshold 10 %, fast mode.
//   In fast mode a report is made only once two consecutive voltages match
//   and are nonzero; from then on every sample reports.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_estimator #(
  parameter int SAMPLE_COUNT = ble_pkg::SAMPLE_COUNT_DEF,
  parameter int ADC_BITS     = ble_pkg::ADC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ble_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ble_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ble_sample_if.sink                          in_ch,
  ble_report_if.source                        out_ch
);

  localparam int IDX_W  = $clog2(SAMPLE_COUNT);
  localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
  localparam int TOT_W  = ADC_BITS + $clog2(SAMPLE_COUNT);
  // trimmed total / (SAMPLE_COUNT-2) as a multiply by a rounded-up reciprocal
  localparam int DIV_D  = SAMPLE_COUNT - 2;
  localparam int DIV_SH = TOT_W + $clog2(DIV_D);
  localparam int DIV_R  = ((2 ** DIV_SH) + DIV_D - 1) / DIV_D;
  localparam int MA_W   = TOT_W;
  localparam int MB_W   = (DIV_SH + 1 > ble_pkg::REF_W) ? DIV_SH + 1 : ble_pkg::REF_W;
  localparam int MP_W   = MA_W + MB_W;
  localparam int PR_W   = ADC_BITS + ble_pkg::REF_W;
  localparam int SC_W   = PR_W + 4;

  ble_pkg::ble_state_e state_q, state_d;
  ble_pkg::ble_seg_e   seg_q, seg_d, seg_c;

  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [TOT_W-1:0]             sum_q, sum_d;
  logic [ADC_BITS-1:0]          min_q, min_d, max_q, max_d;
  logic [ble_pkg::VOLT_W-1:0]   v_q, v_d, last_v_q, last_v_d;
  logic                         slow_q, slow_d;
  logic [ble_pkg::REF_W-1:0]    ref_q;
  logic [ble_pkg::PCT_W-1:0]    low_q;

  logic                         out_valid_q;
  logic                         out_rep_q, out_low_q, out_slow_q;
  logic [ble_pkg::PCT_W-1:0]    out_pct_q;
  logic [ble_pkg::VOLT_W-1:0]   out_v_q;
  logic                         out_load;
  logic                         rep_c;
  logic [ble_pkg::PCT_W-1:0]    pct_c;

  logic                         push;
  logic [ADC_BITS-1:0]          rd_data;
  logic [IDX_W-1:0]             rd_addr;
  logic [MA_W-1:0]              mul_a;
  logic [MB_W-1:0]              mul_b;
  logic [MP_W-1:0]              mul_p;

  logic [TOT_W-1:0]             trimmed;
  logic [PR_W-1:0]              prod_mv;
  logic [SC_W-1:0]              scaled11, scaled;
  logic [ble_pkg::VOLT_W-1:0]   volt_c;
  logic [ble_pkg::OFF_W-1:0]    off_c;

  ble_ring #(
    .DEPTH  (SAMPLE_COUNT),
    .DATA_W (ADC_BITS)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (in_ch.adc_sample),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data)
  );

  ble_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign in_ch.ready = (state_q == ble_pkg::ST_IDLE);
  assign rd_addr     = cnt_q[IDX_W-1:0];
  assign trimmed     = sum_q - TOT_W'(max_q) - TOT_W'(min_q);

  // mean * ref * 11 >> 11, saturated to the voltage field
  assign prod_mv  = mul_p[PR_W-1:0];
  assign scaled11 = (SC_W'(prod_mv) << 3) + (SC_W'(prod_mv) << 1) + SC_W'(prod_mv);
  assign scaled   = scaled11 >> ble_pkg::SCALE_SH;
  assign volt_c   = (scaled > SC_W'(ble_pkg::VOLT_MAX)) ? ble_pkg::VOLT_MAX
                                                        : scaled[ble_pkg::VOLT_W-1:0];

  // curve segment and offset into it
  always_comb begin
    seg_c = ble_pkg::SEG_EMPTY;
    off_c = '0;
    if (v_q > ble_pkg::CURVE_FULL_MV) begin
      seg_c = ble_pkg::SEG_FULL;
    end else if (v_q > ble_pkg::CURVE_HIGH_MV) begin
      seg_c = ble_pkg::SEG_HIGH;
      off_c = ble_pkg::OFF_W'(v_q - ble_pkg::CURVE_HIGH_MV);
    end else if (v_q > ble_pkg::CURVE_MID_MV) begin
      seg_c = ble_pkg::SEG_MID;
      off_c = ble_pkg::OFF_W'(v_q - ble_pkg::CURVE_MID_MV);
    end else if (v_q > ble_pkg::CURVE_LOW_MV) begin
      seg_c = ble_pkg::SEG_LOW;
      off_c = ble_pkg::OFF_W'(v_q - ble_pkg::CURVE_LOW_MV);
    end
  end

  always_comb begin
    case (seg_q)
      ble_pkg::SEG_FULL: pct_c = ble_pkg::PCT_FULL;
      ble_pkg::SEG_HIGH: pct_c = ble_pkg::PCT_HIGH_BASE
                                 + mul_p[ble_pkg::PCT_HIGH_SH +: ble_pkg::PCT_W];
      ble_pkg::SEG_MID:  pct_c = ble_pkg::PCT_MID_BASE
                                 + mul_p[ble_pkg::PCT_MID_SH +: ble_pkg::PCT_W];
      ble_pkg::SEG_LOW:  pct_c = mul_p[ble_pkg::PCT_LOW_SH +: ble_pkg::PCT_W];
      default:           pct_c = '0;
    endcase
  end

  assign rep_c = slow_q || ((v_q == last_v_q) && (v_q != '0));

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    min_d    = min_q;
    max_d    = max_q;
    v_d      = v_q;
    seg_d    = seg_q;
    last_v_d = last_v_q;
    slow_d   = slow_q;
    push     = 1'b0;
    out_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state_q)
      ble_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          push    = 1'b1;
          cnt_d   = '0;
          sum_d   = '0;
          min_d   = '1;
          max_d   = '0;
          state_d = ble_pkg::ST_SCAN;
        end
      end
      ble_pkg::ST_SCAN: begin
        // read data is registered, so it lags the address
        if (cnt_q != '0) begin
          sum_d = sum_q + TOT_W'(rd_data);
          if (rd_data < min_q) min_d = rd_data;
          if (rd_data > max_q) max_d = rd_data;
        end
        if (cnt_q == CNT_W'(SAMPLE_COUNT)) begin
          state_d = ble_pkg::ST_TRIM;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ble_pkg::ST_TRIM: begin
        mul_a   = trimmed;
        mul_b   = MB_W'(DIV_R);
        state_d = ble_pkg::ST_DIV;
      end
      ble_pkg::ST_DIV: begin
        mul_a   = MA_W'(mul_p[DIV_SH +: ADC_BITS]);
        mul_b   = MB_W'(ref_q);
        state_d = ble_pkg::ST_SCALE;
      end
      ble_pkg::ST_SCALE: begin
        v_d     = volt_c;
        state_d = ble_pkg::ST_CURVE;
      end
      ble_pkg::ST_CURVE: begin
        mul_a   = MA_W'(off_c);
        mul_b   = MB_W'(ble_pkg::CURVE_RECIP);
        seg_d   = seg_c;
        state_d = ble_pkg::ST_PCT;
      end
      ble_pkg::ST_PCT: begin
        // keep the curve product in place while the output is stalled
        mul_a = MA_W'(off_c);
        mul_b = MB_W'(ble_pkg::CURVE_RECIP);
        if (!out_valid_q || out_ch.ready) begin
          out_load = 1'b1;
          slow_d   = rep_c;
          last_v_d = v_q;
          state_d  = ble_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ble_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ble_pkg::ST_IDLE;
      last_v_q    <= '0;
      slow_q      <= 1'b0;
      ref_q       <= ble_pkg::REF_MV_RESET;
      low_q       <= ble_pkg::LOW_PCT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      last_v_q <= last_v_d;
      slow_q   <= slow_d;
      if (cfg_we_i) begin
        case (ble_pkg::cfg_idx_e'(cfg_idx_i))
          ble_pkg::CFG_REF_MV:  ref_q <= cfg_data_i[ble_pkg::REF_W-1:0];
          ble_pkg::CFG_LOW_PCT: low_q <= cfg_data_i[ble_pkg::PCT_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    sum_q <= sum_d;
    min_q <= min_d;
    max_q <= max_d;
    v_q   <= v_d;
    seg_q <= seg_d;
    if (out_load) begin
      out_rep_q  <= rep_c;
      out_pct_q  <= rep_c ? pct_c : '0;
      out_low_q  <= rep_c && (pct_c <= low_q);
      out_v_q    <= rep_c ? v_q : '0;
      out_slow_q <= rep_c;
    end
  end

  assign out_ch.valid            = out_valid_q;
  assign out_ch.report_valid     = out_rep_q;
  assign out_ch.battery_percent  = out_pct_q;
  assign out_ch.low_battery      = out_low_q;
  assign out_ch.voltage_mv       = out_v_q;
  assign out_ch.slow_mode_active = out_slow_q;

  // slow mode, once entered, is kept
  a_slow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slow_q |=> slow_q)
    else $error("slow mode dropped");

  // a transfer in always starts the ring scan from the first slot
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> (state_q == ble_pkg::ST_SCAN && cnt_q == '0))
    else $error("scan did not start after input transfer");

  // a silent result carries no level
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.report_valid) |->
      (out_ch.battery_percent == '0 && out_ch.voltage_mv == '0 && !out_ch.low_battery))
    else $error("silent result with nonzero fields");

  // every report leaves the block in slow mode, and the percentage stays on the curve
  a_report_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.report_valid) |->
      (out_ch.slow_mode_active && out_ch.battery_percent <= ble_pkg::PCT_FULL))
    else $error("report outside slow mode or percentage off curve");

  // the output register is never overwritten while it still holds a result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready) |-> !out_load)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- tb/gauge_checker.sv -----
// ----------------------------------------------------------------------------
// gauge_checker
// Watches the sample and report channels of the battery level estimator. It
// keeps its own copy of the sample ring, previous voltage, mode and
// registers, works out each expected report and compares it field by field.
// ----------------------------------------------------------------------------
module gauge_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  ble_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [ble_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ble_sample_if                          in_mon,
  ble_report_if                          out_mon,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             results_o,
  output int                             reports_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 8;

  typedef struct packed {
    logic                       report_valid;
    logic [ble_pkg::PCT_W-1:0]  battery_percent;
    logic                       low_battery;
    logic [ble_pkg::VOLT_W-1:0] voltage_mv;
    logic                       slow_mode_active;
  } level_report_t;

  logic [9:0]                 sample_ring [RING_DEPTH];
  logic [2:0]                 write_slot;
  logic [ble_pkg::VOLT_W-1:0] prev_mv;
  logic                       slow_mode;
  logic [ble_pkg::REF_W-1:0]  ref_mv;
  logic [ble_pkg::PCT_W-1:0]  low_pct;
  level_report_t              expected_levels [$];

  function automatic logic [ble_pkg::PCT_W-1:0] charge_percent(input int unsigned mv);
    if (mv > 4200) return 7'(100);
    if (mv > 4000) return 7'(90 + (mv - 4000) / 20);
    if (mv > 3600) return 7'(10 + (mv - 3600) / 5);
    if (mv > 3200) return 7'((mv - 3200) / 40);
    return '0;
  endfunction

  // Advances the mirrored state by one sample and returns the report it gives
  task automatic estimate_level(input logic [9:0] sample, output level_report_t rep);
    int unsigned total, lo, hi, mean, mv;
    logic        publish;
    sample_ring[write_slot] = sample;
    write_slot = write_slot + 3'd1;
    total = 0;
    lo    = 32'hFFFF_FFFF;
    hi    = 0;
    foreach (sample_ring[i]) begin
      total += sample_ring[i];
      if (sample_ring[i] > hi) hi = sample_ring[i];
      if (sample_ring[i] < lo) lo = sample_ring[i];
    end
    mean = (total - hi - lo) / (RING_DEPTH - 2);
    mv   = (mean * ref_mv * 11) >> 11;
    if (mv > 32767) mv = 32767;
    if (slow_mode) begin
      publish = 1'b1;
    end else if (mv == prev_mv && mv != 0) begin
      slow_mode = 1'b1;
      publish   = 1'b1;
    end else begin
      publish = 1'b0;
    end
    prev_mv = ble_pkg::VOLT_W'(mv);
    rep.report_valid     = publish;
    rep.battery_percent  = publish ? charge_percent(mv) : '0;
    rep.low_battery      = publish && (charge_percent(mv) <= low_pct);
    rep.voltage_mv       = publish ? ble_pkg::VOLT_W'(mv) : '0;
    rep.slow_mode_active = slow_mode;
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    level_report_t exp_rep;
    if (!rst_ni) begin
      foreach (sample_ring[i]) sample_ring[i] = '0;
      write_slot   = '0;
      prev_mv      = '0;
      slow_mode    = 1'b0;
      ref_mv       = ble_pkg::REF_MV_RESET;
      low_pct      = ble_pkg::LOW_PCT_RESET;
      fail_count_o = 0;
      results_o    = 0;
      reports_o    = 0;
      expected_levels.delete();
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ble_pkg::CFG_REF_MV:  ref_mv  = cfg_data_i[ble_pkg::REF_W-1:0];
          ble_pkg::CFG_LOW_PCT: low_pct = cfg_data_i[ble_pkg::PCT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        estimate_level(in_mon.adc_sample, exp_rep);
        expected_levels.push_back(exp_rep);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_levels.size() == 0) begin
          $error("report transfer with no expected result pending");
          fail_count_o++;
        end else begin
          exp_rep = expected_levels.pop_front();
          results_o++;
          if (out_mon.report_valid) reports_o++;
          check_field("report_valid", exp_rep.report_valid, out_mon.report_valid);
          check_field("battery_percent", exp_rep.battery_percent,
                      out_mon.battery_percent);
          check_field("low_battery", exp_rep.low_battery, out_mon.low_battery);
          check_field("voltage_mv", exp_rep.voltage_mv, out_mon.voltage_mv);
          check_field("slow_mode_active", exp_rep.slow_mode_active,
                      out_mon.slow_mode_active);
        end
      end
      pending_o = expected_levels.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives ADC samples and register writes into the battery level estimator
// with random gaps and output stalls; the checker beside it predicts and
// compares every report. Runs fast-mode start-up, extremes and random plateaus
// of battery-like samples under several reference and threshold settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASE_ITEMS  = 192;
  localparam int RAND_PHASES  = 8;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  ble_pkg::cfg_idx_e              cfg_idx;
  logic [ble_pkg::CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending, results, reports;
  int cycles;
  int items_sent;
  int cur_ref;
  bit gap_en;
  bit stall_en;
  int stall_hold;

  ble_sample_if in_ch ();
  ble_report_if out_ch ();

  battery_level_estimator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  gauge_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .reports_o    (reports)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: ready runs alternate with random stall bursts
  always @(negedge clk_i) begin
    if (!stall_en) begin
      out_ch.ready <= 1'b1;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if (out_ch.ready && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_hold = $urandom_range(0, 15);
    end else begin
      out_ch.ready <= 1'b1;
      stall_hold = $urandom_range(0, 24);
    end
  end

  // Both registers, on consecutive cycles; called at a falling edge while idle
  task automatic write_config(input int ref_val, input int low_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= ble_pkg::CFG_REF_MV;
    cfg_data <= ble_pkg::CFG_DATA_W'(ref_val);
    @(negedge clk_i);
    cfg_idx  <= ble_pkg::CFG_LOW_PCT;
    cfg_data <= ble_pkg::CFG_DATA_W'(low_val);
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    cur_ref = ref_val;
  endtask

  task automatic send_sample(input int sample);
    int gap;
    gap = (gap_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= 10'(sample);
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Plateaus of samples near a battery-like voltage, with spikes and noise
  task automatic run_phase(input int n_items);
    int sent, lvl, run_len, s;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample($urandom_range(0, 1023));
        sent++;
      end else begin
        if (cur_ref == 0 || $urandom_range(0, 9) == 0)
          lvl = $urandom_range(0, 1023);
        else
          lvl = $urandom_range(2900, 4500) * 2048 / (cur_ref * 11);
        if (lvl > 1023) lvl = 1023;
        run_len = $urandom_range(4, 40);
        for (int k = 0; k < run_len && sent < n_items; k++) begin
          if ($urandom_range(0, 15) == 0) begin
            s = $urandom_range(0, 1023);
          end else begin
            s = lvl + $urandom_range(0, 4) - 2;
            if (s < 0) s = 0;
            if (s > 1023) s = 1023;
          end
          send_sample(s);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int ref_list [RAND_PHASES];
    int low_list [RAND_PHASES];
    int ref_val, low_val;
    ref_list = '{1200, 1, 4095, 3600, -1, -1, 0, 1200};
    low_list = '{10, 0, 100, 127, -1, -1, 50, 30};
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = ble_pkg::CFG_REF_MV;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.adc_sample = '0;
    out_ch.ready     = 1'b0;
    stall_hold       = 0;
    gap_en           = 1'b1;
    stall_en         = 1'b1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero reference: voltage stays 0, fast mode must not report
    write_config(0, 100);
    foreach (ref_list[i]) if (i < 4) send_sample(i == 0 ? 1023 : (i == 1 ? 512 : 1 - i / 3));
    drain();

    // Alternating and steady samples; the first repeated nonzero voltage switches to slow mode
    write_config(3600, 127);
    for (int k = 0; k < 4; k++) send_sample(k[0] ? 0 : 1023);
    repeat (10) send_sample(700);
    send_sample(1023);
    send_sample(0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      ref_val = ref_list[p] < 0 ? $urandom_range(1, 4095) : ref_list[p];
      low_val = low_list[p] < 0 ? $urandom_range(0, 127) : low_list[p];
      write_config(ref_val, low_val);
      gap_en   = (p != RAND_PHASES - 1);
      stall_en = (p != RAND_PHASES - 1);
      run_phase(PHASE_ITEMS);
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("Covered %0d samples over %0d register settings, including fast-mode start-up",
             items_sent, RAND_PHASES + 2);
    $display("Checked %0d results, %0d of them published reports", results, reports);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ble_pkg.sv
rtl/ble_if.sv
rtl/ble_ring.sv
rtl/ble_mul.sv
rtl/battery_level_estimator.sv
tb/gauge_checker.sv
tb/tb_top.sv
